@@ sv/yags_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YAGS predictor package
// Kind codes, decoded operations, back-end states and the queue item type.
// ----------------------------------------------------------------------------
package yags_pkg;

    localparam int KIND_W = 3;
    localparam int HIST_W = 13;

    localparam logic [KIND_W-1:0] KIND_PREDICT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SHIFT   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RESTORE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_COMMIT  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_REPAIR  = 3'd4;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_PREDICT,
        OP_SHIFT,
        OP_RESTORE,
        OP_COMMIT,
        OP_REPAIR
    } op_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ,
        BK_EXEC
    } bk_state_t;

    typedef struct packed {
        op_t               op;
        logic [1:0]        thread;
        logic              uncond;
        logic              taken;
        logic [HIST_W-1:0] saved;
        logic              rec_choice;
        logic              rec_taken_used;
        logic              rec_not_taken_used;
        logic              rec_final;
    } item_t;

    typedef struct packed {
        logic pop;
        logic clearing;
    } bk_status_t;

endpackage

@@ sv/yags_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YAGS front end
// Accepts transactions, decodes the kind, shifts the PC and queues the item.
// ----------------------------------------------------------------------------
module yags_front import yags_pkg::*; #(
    parameter int SPC_BITS = 13,
    parameter int THREADS  = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_wr_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [KIND_W-1:0]   in_kind,
    input  logic [1:0]          in_thread,
    input  logic [63:0]         in_pc,
    input  logic                in_uncond,
    input  logic                in_taken,
    input  logic [HIST_W-1:0]   in_saved,
    input  logic [3:0]          in_rec,
    input  bk_status_t          bk_status,
    output logic                item_valid,
    output item_t               item,
    output logic [SPC_BITS-1:0] item_spc
);

    logic [2:0]          shift_reg;
    item_t               q_item_reg [2];
    logic [SPC_BITS-1:0] q_spc_reg  [2];
    logic                wr_ptr_reg, wr_ptr_next;
    logic                rd_ptr_reg, rd_ptr_next;
    logic [1:0]          count_reg, count_next;
    logic                push;
    item_t               new_item;
    logic [63:0]         spc_full;

    always_comb begin
        new_item.thread             = in_thread;
        new_item.uncond             = in_uncond;
        new_item.taken              = in_taken;
        new_item.saved              = in_saved;
        new_item.rec_choice         = in_rec[0];
        new_item.rec_taken_used     = in_rec[1];
        new_item.rec_not_taken_used = in_rec[2];
        new_item.rec_final          = in_rec[3];
        if (32'(in_thread) >= THREADS) begin
            new_item.op = OP_NONE;
        end else begin
            case (in_kind)
                KIND_PREDICT: new_item.op = OP_PREDICT;
                KIND_SHIFT:   new_item.op = OP_SHIFT;
                KIND_RESTORE: new_item.op = OP_RESTORE;
                KIND_COMMIT:  new_item.op = OP_COMMIT;
                KIND_REPAIR:  new_item.op = OP_REPAIR;
                default:      new_item.op = OP_NONE;
            endcase
        end
    end

    assign spc_full = in_pc >> shift_reg;
    assign in_ready = (count_reg != 2'd2) && !bk_status.clearing;
    assign push     = in_valid && in_ready;

    assign item_valid = (count_reg != 2'd0);
    assign item       = q_item_reg[rd_ptr_reg];
    assign item_spc   = q_spc_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = bk_status.pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(bk_status.pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg  <= 3'd2;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (cfg_wr_en) begin
                shift_reg <= cfg_wr_data;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_item_reg[wr_ptr_reg] <= new_item;
            q_spc_reg[wr_ptr_reg]  <= spc_full[SPC_BITS-1:0];
        end
    end

endmodule

@@ sv/yags_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YAGS back end
// Holds history and tables; reads, evaluates and writes back one item a pass.
// ----------------------------------------------------------------------------
module yags_back import yags_pkg::*; #(
    parameter int CHOICE_ENTRIES    = 8192,
    parameter int EXCEPTION_ENTRIES = 8192,
    parameter int TAG_BITS          = 8,
    parameter int CHOICE_CTR_BITS   = 2,
    parameter int EXC_CTR_BITS      = 2,
    parameter int THREADS           = 4,
    parameter int SPC_BITS          = 13
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    input  item_t               item,
    input  logic [SPC_BITS-1:0] item_spc,
    output bk_status_t          bk_status,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_prediction,
    output logic [HIST_W-1:0]   out_snapshot,
    output logic                out_choice,
    output logic                out_taken_used,
    output logic                out_not_taken_used
);

    localparam int CIDX   = $clog2(CHOICE_ENTRIES);
    localparam int EIDX   = $clog2(EXCEPTION_ENTRIES);
    localparam int HB     = EIDX;
    localparam int SNAP_N = (HB < HIST_W) ? HB : HIST_W;
    localparam int CLR_N  = (CHOICE_ENTRIES > EXCEPTION_ENTRIES) ?
                            CHOICE_ENTRIES : EXCEPTION_ENTRIES;
    localparam int CLR_W  = $clog2(CLR_N);
    localparam int CB     = CHOICE_CTR_BITS;
    localparam int EB     = EXC_CTR_BITS;
    localparam int TW     = TAG_BITS + 1;
    localparam logic [EB-1:0] EX_WEAK_T  = EB'(1) << (EB - 1);
    localparam logic [EB-1:0] EX_WEAK_NT = EX_WEAK_T - EB'(1);

    function automatic logic [EB-1:0] ex_move(input logic [EB-1:0] c, input logic up);
        if (up) begin
            return (c != '1) ? c + EB'(1) : c;
        end
        return (c != '0) ? c - EB'(1) : c;
    endfunction

    function automatic logic [CB-1:0] ch_move(input logic [CB-1:0] c, input logic up);
        if (up) begin
            return (c != '1) ? c + CB'(1) : c;
        end
        return (c != '0) ? c - CB'(1) : c;
    endfunction

    bk_state_t state_reg, state_next;
    logic [CLR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [HB-1:0] hist_reg [THREADS];
    item_t cur_reg;
    logic [CIDX-1:0] cidx_reg;
    logic [EIDX-1:0] eidx_reg;
    logic [TAG_BITS-1:0] tag_reg;
    logic [HB-1:0] h_reg;
    logic [HB-1:0] cur_saved;

    logic [CB-1:0] cc_mem  [CHOICE_ENTRIES];
    logic [EB-1:0] tc_mem  [EXCEPTION_ENTRIES];
    logic [EB-1:0] ntc_mem [EXCEPTION_ENTRIES];
    logic [TW-1:0] tt_mem  [EXCEPTION_ENTRIES];
    logic [TW-1:0] ntt_mem [EXCEPTION_ENTRIES];
    logic [CB-1:0] cc_rd;
    logic [EB-1:0] tc_rd, ntc_rd;
    logic [TW-1:0] tt_rd, ntt_rd;

    logic out_valid_reg, out_pred_reg, out_choice_reg, out_tu_reg, out_ntu_reg;
    logic [HIST_W-1:0] out_snap_reg;

    // front-of-queue lookup
    logic [HB-1:0] h_sel, saved_h;
    logic [EIDX-1:0] eidx_new;
    logic pop, clearing, exec_done, tbl_we, tag_t_we, tag_nt_we;
    logic [CIDX-1:0] c_addr;
    logic [EIDX-1:0] e_addr;

    always_comb begin
        h_sel = '0;
        for (int t = 0; t < THREADS; t++) begin
            if (32'(item.thread) == t) begin
                h_sel = hist_reg[t];
            end
        end
        saved_h  = HB'(item.saved[SNAP_N-1:0]);
        eidx_new = item_spc[EIDX-1:0] ^ ((item.op == OP_PREDICT) ? h_sel : saved_h);
    end

    assign cur_saved = HB'(cur_reg.saved[SNAP_N-1:0]);

    // next state
    always_comb begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            BK_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + CLR_W'(1);
                if (clr_cnt_reg == CLR_W'(CLR_N - 1)) begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE: if (item_valid) state_next = BK_READ;
            BK_READ: state_next = BK_EXEC;
            BK_EXEC: if (!out_valid_reg || out_ready) state_next = BK_IDLE;
            default: state_next = BK_CLEAR;
        endcase
    end

    // control outputs
    always_comb begin
        clearing  = (state_reg == BK_CLEAR);
        pop       = (state_reg == BK_IDLE) && item_valid;
        exec_done = (state_reg == BK_EXEC) && (!out_valid_reg || out_ready);
    end

    assign bk_status.pop      = pop;
    assign bk_status.clearing = clearing;

    // evaluate current item
    logic choice, t_hit, nt_hit, t_used, nt_used, fin, commit, miss;
    logic [CB-1:0] cc_wd;
    logic [EB-1:0] tc_wd, ntc_wd;

    always_comb begin
        choice  = cc_rd[CB-1];
        t_hit   = tt_rd[TW-1] && (tt_rd[TAG_BITS-1:0] == tag_reg);
        nt_hit  = ntt_rd[TW-1] && (ntt_rd[TAG_BITS-1:0] == tag_reg);
        nt_used = choice && nt_hit;
        t_used  = !choice && t_hit;
        fin     = choice;
        if (nt_used) fin = ntc_rd[EB-1];
        if (t_used)  fin = tc_rd[EB-1];

        commit = (cur_reg.op == OP_COMMIT);
        miss   = (cur_reg.rec_final != cur_reg.taken);
        tc_wd  = tc_rd;
        ntc_wd = ntc_rd;
        if (!cur_reg.rec_choice && cur_reg.taken) begin
            tc_wd = ex_move(tc_rd, 1'b1);
        end else begin
            if (cur_reg.rec_taken_used) tc_wd = ex_move(tc_rd, cur_reg.taken);
            if (cur_reg.rec_choice && !cur_reg.taken) begin
                ntc_wd = ex_move(ntc_rd, 1'b0);
            end else if (cur_reg.rec_not_taken_used) begin
                ntc_wd = ex_move(ntc_rd, cur_reg.taken);
            end
        end
        tag_t_we  = !cur_reg.rec_taken_used && !cur_reg.rec_choice && miss;
        tag_nt_we = !cur_reg.rec_not_taken_used && cur_reg.rec_choice && miss;
        if (tag_t_we)  tc_wd  = EX_WEAK_T;
        if (tag_nt_we) ntc_wd = EX_WEAK_NT;
        cc_wd = cc_rd;
        if (miss || (cur_reg.rec_final == cur_reg.rec_choice)) begin
            cc_wd = ch_move(cc_rd, cur_reg.taken);
        end
        tbl_we = exec_done && commit;
        c_addr = clearing ? CIDX'(clr_cnt_reg) : cidx_reg;
        e_addr = clearing ? EIDX'(clr_cnt_reg) : eidx_reg;
    end

    always_ff @(posedge aclk) begin
        if (clearing) begin
            cc_mem[c_addr] <= '0;
        end else if (tbl_we) begin
            cc_mem[c_addr] <= cc_wd;
        end
        cc_rd <= cc_mem[c_addr];
    end

    always_ff @(posedge aclk) begin
        if (clearing) begin
            tc_mem[e_addr]  <= '0;
            ntc_mem[e_addr] <= '0;
        end else if (tbl_we) begin
            tc_mem[e_addr]  <= tc_wd;
            ntc_mem[e_addr] <= ntc_wd;
        end
        tc_rd  <= tc_mem[e_addr];
        ntc_rd <= ntc_mem[e_addr];
    end

    always_ff @(posedge aclk) begin
        if (clearing) begin
            tt_mem[e_addr]  <= '0;
            ntt_mem[e_addr] <= '0;
        end else begin
            if (tbl_we && tag_t_we)  tt_mem[e_addr]  <= {1'b1, tag_reg};
            if (tbl_we && tag_nt_we) ntt_mem[e_addr] <= {1'b1, tag_reg};
        end
        tt_rd  <= tt_mem[e_addr];
        ntt_rd <= ntt_mem[e_addr];
    end

    // latch the popped item and register the results
    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg  <= item;
            cidx_reg <= item_spc[CIDX-1:0];
            eidx_reg <= eidx_new;
            tag_reg  <= item_spc[TAG_BITS-1:0];
            h_reg    <= h_sel;
        end
        if (exec_done) begin
            out_pred_reg   <= 1'b0;
            out_snap_reg   <= '0;
            out_choice_reg <= 1'b0;
            out_tu_reg     <= 1'b0;
            out_ntu_reg    <= 1'b0;
            if (cur_reg.op == OP_PREDICT) begin
                out_snap_reg <= HIST_W'(h_reg);
                if (cur_reg.uncond) begin
                    out_pred_reg   <= 1'b1;
                    out_choice_reg <= 1'b1;
                    out_ntu_reg    <= 1'b1;
                end else begin
                    out_pred_reg   <= fin;
                    out_choice_reg <= choice;
                    out_tu_reg     <= t_used;
                    out_ntu_reg    <= nt_used;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int t = 0; t < THREADS; t++) begin
                hist_reg[t] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (exec_done) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (exec_done) begin
                for (int t = 0; t < THREADS; t++) begin
                    if (32'(cur_reg.thread) == t) begin
                        case (cur_reg.op)
                            OP_SHIFT:   hist_reg[t] <= {hist_reg[t][HB-2:0], cur_reg.taken};
                            OP_RESTORE: hist_reg[t] <= cur_saved;
                            OP_REPAIR:  hist_reg[t] <= {cur_saved[HB-2:0], cur_reg.taken};
                            default:    hist_reg[t] <= hist_reg[t];
                        endcase
                    end
                end
            end
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_prediction     = out_pred_reg;
    assign out_snapshot       = out_snap_reg;
    assign out_choice         = out_choice_reg;
    assign out_taken_used     = out_tu_reg;
    assign out_not_taken_used = out_ntu_reg;

endmodule

@@ sv/yags_branch_predictor.sv @@
`timescale 1ns / 1ps
// Path: an input transaction is queued in the front end, popped into the back end,
// read in BK_READ, evaluated in BK_EXEC and registered onto m_axis_tvalid.
// The back end takes one item at a time: its read then write-back pass over the
// single-port table memories ends before it pops the next item.
// Reset: synchronous; afterwards a clearing pass zeroes the tables while s_axis_tready stays low.
// ----------------------------------------------------------------------------
// YAGS branch predictor
// Front end decodes and queues transactions; back end owns history and tables.
// ----------------------------------------------------------------------------
module yags_branch_predictor import yags_pkg::*; #(
    parameter int CHOICE_ENTRIES    = 8192,
    parameter int EXCEPTION_ENTRIES = 8192,
    parameter int TAG_BITS          = 8,
    parameter int CHOICE_CTR_BITS   = 2,
    parameter int EXC_CTR_BITS      = 2,
    parameter int THREADS           = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_wr_data,   // inst_shift
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // thread[1:0], pc[65:2], uncond[66], taken[67], saved_history[80:68],
    // rec_choice[81], rec_taken_used[82], rec_not_taken_used[83], rec_final[84]
    input  logic [87:0] s_axis_tdata,
    input  logic [2:0]  s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // prediction[0], history_snapshot[13:1], choice_pred[14], taken_used[15],
    // not_taken_used[16]
    output logic [23:0] m_axis_tdata
);

    localparam int CIDX_W = $clog2(CHOICE_ENTRIES);
    localparam int EIDX_W = $clog2(EXCEPTION_ENTRIES);
    localparam int SPC_A  = (CIDX_W > EIDX_W) ? CIDX_W : EIDX_W;
    localparam int SPC_BITS = (SPC_A > TAG_BITS) ? SPC_A : TAG_BITS;

    bk_status_t          bk_status;
    logic                item_valid;
    item_t               item;
    logic [SPC_BITS-1:0] item_spc;
    logic                pred, choice, tu, ntu;
    logic [HIST_W-1:0]   snap;

    yags_front #(
        .SPC_BITS (SPC_BITS),
        .THREADS  (THREADS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_kind     (s_axis_tuser),
        .in_thread   (s_axis_tdata[1:0]),
        .in_pc       (s_axis_tdata[65:2]),
        .in_uncond   (s_axis_tdata[66]),
        .in_taken    (s_axis_tdata[67]),
        .in_saved    (s_axis_tdata[80:68]),
        .in_rec      (s_axis_tdata[84:81]),
        .bk_status   (bk_status),
        .item_valid  (item_valid),
        .item        (item),
        .item_spc    (item_spc)
    );

    yags_back #(
        .CHOICE_ENTRIES    (CHOICE_ENTRIES),
        .EXCEPTION_ENTRIES (EXCEPTION_ENTRIES),
        .TAG_BITS          (TAG_BITS),
        .CHOICE_CTR_BITS   (CHOICE_CTR_BITS),
        .EXC_CTR_BITS      (EXC_CTR_BITS),
        .THREADS           (THREADS),
        .SPC_BITS          (SPC_BITS)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .item_valid         (item_valid),
        .item               (item),
        .item_spc           (item_spc),
        .bk_status          (bk_status),
        .out_valid          (m_axis_tvalid),
        .out_ready          (m_axis_tready),
        .out_prediction     (pred),
        .out_snapshot       (snap),
        .out_choice         (choice),
        .out_taken_used     (tu),
        .out_not_taken_used (ntu)
    );

    assign m_axis_tdata = {7'd0, ntu, tu, choice, snap, pred};

endmodule

@@ sv/yags_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// YAGS port checker
// Watches the top-level ports for handshake, reset and result consistency.
// ----------------------------------------------------------------------------
module yags_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid && !s_axis_tready)
        else $error("ports active right after reset");

    a_taken_used: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[15] |-> !m_axis_tdata[14] && !m_axis_tdata[16])
        else $error("taken cache used against a taken bias");

    a_nt_used: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tdata[14])
        else $error("not-taken cache used without a taken bias");

endmodule

bind yags_branch_predictor yags_checker u_yags_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
